### rtl/core/rlcf_pkg.sv
`timescale 1ns / 1ps

package rlcf_pkg;

    localparam int UPDATE_PERIOD_MS = 10;

    localparam int COLOUR_W  = 8;
    localparam int ELAPSED_W = 8;
    localparam int MS_W      = 15;
    localparam int COUNT_W   = 17;
    localparam int TOTAL_W   = 16;
    localparam int PROD_W    = COLOUR_W + COUNT_W;
    localparam int QUOT_W    = MS_W;
    localparam int DIV_CNT_W = 4;
    localparam int DSH_W     = TOTAL_W + QUOT_W - 1;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 31;

    localparam logic [DIV_CNT_W-1:0] DIV_ITERS_BLEND = DIV_CNT_W'(COLOUR_W);
    localparam logic [COUNT_W-1:0]   COUNT_MAX       = {COUNT_W{1'b1}};
    // The reciprocal is rounded up, which keeps the quotient exact for every duration.
    localparam logic [RECIP_W-1:0]   PERIOD_RECIP    =
        RECIP_W'((64'd1 << RECIP_SHIFT) / UPDATE_PERIOD_MS + 1);

    typedef enum logic
    {
        OP_REFRESH = 1'b0,
        OP_SET     = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                              op;
        logic [ELAPSED_W-1:0]             elapsed;
        logic [2:0][COLOUR_W-1:0]         target;
        logic [MS_W-1:0]                  fade_ms;
    } item_t;

    typedef struct packed
    {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
        logic [PROD_W-1:0]    dividend;
        logic [TOTAL_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed
    {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/core/rlcf_front.sv
`timescale 1ns / 1ps

module rlcf_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,
    input  logic                 s_tuser,
    output logic                 push_valid,
    input  logic                 push_ready,
    output rlcf_pkg::item_t      push_item
);
    import rlcf_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        item_next.op        = s_tuser ? OP_SET : OP_REFRESH;
        item_next.elapsed   = s_tdata[7:0];
        item_next.target[0] = s_tdata[15:8];
        item_next.target[1] = s_tdata[23:16];
        item_next.target[2] = s_tdata[31:24];
        item_next.fade_ms   = s_tdata[46:32];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### rtl/core/rlcf_queue.sv
`timescale 1ns / 1ps

module rlcf_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  rlcf_pkg::item_t  push_item,
    output logic             pop_valid,
    input  logic             pop,
    output rlcf_pkg::item_t  pop_item
);
    import rlcf_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/rlcf_div.sv
`timescale 1ns / 1ps

module rlcf_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  rlcf_pkg::div_req_t  req,
    output rlcf_pkg::div_rsp_t  rsp
);
    import rlcf_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [PROD_W-1:0]    rem_reg;
    logic [DSH_W-1:0]     dsh_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic                 fits;

    // One quotient bit a cycle, most significant first, against the shifted divisor.
    assign fits = ({(DSH_W - PROD_W)'(0), rem_reg} >= dsh_reg);

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.dividend;
            dsh_reg  <= {(DSH_W - TOTAL_W)'(0), req.divisor} << (req.iters - DIV_CNT_W'(1));
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg[PROD_W-1:0];
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

endmodule

### rtl/core/rlcf_back.sv
`timescale 1ns / 1ps

module rlcf_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop,
    input  rlcf_pkg::item_t  pop_item,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata
);
    import rlcf_pkg::*;

    typedef enum logic [3:0]
    {
        ST_IDLE   = 4'b0001,
        ST_MUL    = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [2:0][COLOUR_W-1:0]  start_reg;
    logic [2:0][COLOUR_W-1:0]  start_next;
    logic [2:0][COLOUR_W-1:0]  target_reg;
    logic [2:0][COLOUR_W-1:0]  target_next;
    logic [2:0][COLOUR_W-1:0]  present_reg;
    logic [2:0][COLOUR_W-1:0]  present_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic [TOTAL_W-1:0]        total_reg;
    logic [TOTAL_W-1:0]        total_next;
    logic [1:0]                ch_reg;
    logic [1:0]                ch_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [23:0]               out_data_reg;
    logic                      div_start_reg;
    logic                      div_start_next;
    logic [DIV_CNT_W-1:0]      div_iters_reg;
    logic [DIV_CNT_W-1:0]      div_iters_next;
    logic [PROD_W-1:0]         div_dividend_reg;
    logic [PROD_W-1:0]         div_dividend_next;
    logic [TOTAL_W-1:0]        div_divisor_reg;
    logic [TOTAL_W-1:0]        div_divisor_next;
    logic                      neg_reg;
    logic                      neg_next;

    logic [COUNT_W:0]          count_sum;
    logic [COUNT_W-1:0]        count_sat;
    logic [COLOUR_W-1:0]       ch_start;
    logic [COLOUR_W-1:0]       ch_target;
    logic [COLOUR_W-1:0]       abs_diff;
    logic [COLOUR_W-1:0]       part;
    logic [MS_W+RECIP_W-1:0]   set_prod;
    logic [MS_W-1:0]           set_quot;
    logic                      out_load;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    rlcf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_req.start    = div_start_reg;
    assign div_req.iters    = div_iters_reg;
    assign div_req.dividend = div_dividend_reg;
    assign div_req.divisor  = div_divisor_reg;

    assign pop      = (state_reg == ST_IDLE) && pop_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    assign count_sum = {1'b0, count_reg} + (COUNT_W + 1)'(pop_item.elapsed);
    assign count_sat = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
    assign ch_start  = start_reg[ch_reg];
    assign ch_target = target_reg[ch_reg];
    assign abs_diff  = (ch_target < ch_start) ? (ch_start - ch_target) : (ch_target - ch_start);
    assign part      = div_rsp.quotient[COLOUR_W-1:0];
    assign set_prod  = (MS_W + RECIP_W)'(pop_item.fade_ms) * (MS_W + RECIP_W)'(PERIOD_RECIP);
    assign set_quot  = set_prod[RECIP_SHIFT +: MS_W];

    always_comb
    begin
        state_next        = state_reg;
        start_next        = start_reg;
        target_next       = target_reg;
        present_next      = present_reg;
        count_next        = count_reg;
        total_next        = total_reg;
        ch_next           = ch_reg;
        div_start_next    = 1'b0;
        div_iters_next    = div_iters_reg;
        div_dividend_next = div_dividend_reg;
        div_divisor_next  = div_divisor_reg;
        neg_next          = neg_reg;
        out_valid_next    = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    unique case (pop_item.op)
                        OP_SET:
                        begin
                            start_next  = present_reg;
                            target_next = pop_item.target;
                            count_next  = '0;
                            total_next  = TOTAL_W'(set_quot) + TOTAL_W'(1);
                        end
                        OP_REFRESH:
                        begin
                            if (count_sat >= COUNT_W'(total_reg))
                            begin
                                count_next = '0;
                                start_next = target_reg;
                            end
                            else
                            begin
                                count_next = count_sat;
                            end
                            ch_next    = 2'd0;
                            state_next = ST_MUL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                neg_next          = (ch_target < ch_start);
                div_dividend_next = PROD_W'(abs_diff) * PROD_W'(count_reg);
                div_divisor_next  = total_reg;
                div_iters_next    = DIV_ITERS_BLEND;
                div_start_next    = 1'b1;
                state_next        = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    present_next[ch_reg] = neg_reg ? (ch_start - part) : (ch_start + part);
                    if (ch_reg == 2'd2)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= '0;
            target_reg    <= '0;
            present_reg   <= '0;
            count_reg     <= '0;
            total_reg     <= TOTAL_W'(1);
            ch_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            target_reg    <= target_next;
            present_reg   <= present_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            div_start_reg <= div_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_iters_reg    <= div_iters_next;
        div_dividend_reg <= div_dividend_next;
        div_divisor_reg  <= div_divisor_next;
        neg_reg          <= neg_next;
        if (out_load)
        begin
            out_data_reg <= ~{present_reg[2], present_reg[1], present_reg[0]};
        end
    end

endmodule

### rtl/core/rgb_linear_colour_fade.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals                          Content
// s_*       in         tvalid, tready, tdata, tuser     colour set or refresh items
// m_*       out        tvalid, tready, tdata            inverted duties, one per refresh
//
// A set transfer is handled by the back end in its idle state, where multiplying by the
// reciprocal of the update period gives the step total. A refresh takes the item, then
// runs a multiply and a serial division for each channel, and then loads the output.
// Reset clears the colours and step count and sets the step total to one.
// The input register and a two-entry queue keep accepting while the back end works.
// A result waiting in the output register holds the next one only at its output step.

module rgb_linear_colour_fade
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // elapsed_periods, target_red, target_green, target_blue,
                                  // fade_ms, one zero pad bit
    input  logic        s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // duty_red, duty_green, duty_blue
);
    import rlcf_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop;
    item_t pop_item;

    rlcf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    rlcf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    rlcf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
